### src/accumulator_cpu_core_defines.svh
// Assertion macros shared by the accumulator core RTL.
// Every use assumes the module has i_clk and i_rst_n.
`ifndef ACCUMULATOR_CPU_CORE_DEFINES_SVH
`define ACCUMULATOR_CPU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ACC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");
`define ACC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("%m: check failed");
`define ACC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("%m: check failed");
`else
`define ACC_ASSERT(label, prop)
`define ACC_ASSERT_IMP(label, ante, cons)
`define ACC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/acc_cpu_pkg.sv
`default_nettype none
package acc_cpu_pkg;

    localparam int MODE_W = 2;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int ST_W   = 3;
    localparam int SP_W   = 9;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXEC  = 2'd2;

    localparam logic [DATA_W-1:0] OP_PUSH_B  = 8'h01;
    localparam logic [DATA_W-1:0] OP_POP_B   = 8'h02;
    localparam logic [DATA_W-1:0] OP_LOAD_A  = 8'h03;
    localparam logic [DATA_W-1:0] OP_LOAD_B  = 8'h04;
    localparam logic [DATA_W-1:0] OP_STORE_A = 8'h05;
    localparam logic [DATA_W-1:0] OP_ADD     = 8'h10;
    localparam logic [DATA_W-1:0] OP_SUB     = 8'h11;
    localparam logic [DATA_W-1:0] OP_JMP     = 8'h20;
    localparam logic [DATA_W-1:0] OP_SYSCALL = 8'h30;
    localparam logic [DATA_W-1:0] OP_HALT    = 8'hFF;

    localparam logic [DATA_W-1:0] SYS_PUTC = 8'h01;
    localparam logic [DATA_W-1:0] SYS_GETC = 8'h02;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_HALT   = 3'd1;
    localparam logic [ST_W-1:0] ST_BADOP  = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE  = 3'd3;
    localparam logic [ST_W-1:0] ST_BADSYS = 3'd4;

    typedef logic [1:0] t_msel;
    localparam t_msel MSEL_IN  = 2'd0;
    localparam t_msel MSEL_PC  = 2'd1;
    localparam t_msel MSEL_PC1 = 2'd2;

    typedef struct packed {
        logic  cap_in;
        logic  mem_re;
        t_msel mem_sel;
        logic  cap_op;
        logic  stk_re;
        logic  exec;
        logic  range_err;
    } t_cmd;

    typedef struct packed {
        logic addr_ok;
        logic pc_ok;
        logic pc1_ok;
        logic has_opnd;
        logic pop_ok;
        logic out_free;
    } t_stat;

    function automatic logic f_has_opnd(input logic [DATA_W-1:0] op);
        return (op == OP_LOAD_A) || (op == OP_LOAD_B) || (op == OP_STORE_A) ||
               (op == OP_JMP);
    endfunction

endpackage
`default_nettype wire

### src/acc_cpu_ram.sv
`default_nettype none
module acc_cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/acc_cpu_ctrl.sv
`default_nettype none
`include "accumulator_cpu_core_defines.svh"
module acc_cpu_ctrl
    import acc_cpu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OP   = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_range, n_range;

    always_comb begin
        n_state = r_state;
        n_range = r_range;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_range      = 1'b0;
                    n_state      = S_EXEC;
                    case (i_mode)
                        MODE_READ: begin
                            if (i_stat.addr_ok) begin
                                o_cmd.mem_re  = 1'b1;
                                o_cmd.mem_sel = MSEL_IN;
                            end
                        end
                        MODE_EXEC: begin
                            if (i_stat.pc_ok) begin
                                o_cmd.mem_re  = 1'b1;
                                o_cmd.mem_sel = MSEL_PC;
                                n_state       = S_OP;
                            end else begin
                                n_range = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_OP: begin
                o_cmd.cap_op = 1'b1;
                n_state      = S_EXEC;
                if (i_stat.has_opnd) begin
                    if (i_stat.pc1_ok) begin
                        o_cmd.mem_re  = 1'b1;
                        o_cmd.mem_sel = MSEL_PC1;
                    end else begin
                        n_range = 1'b1;
                    end
                end else if (i_stat.pop_ok) begin
                    o_cmd.stk_re = 1'b1;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec      = 1'b1;
                    o_cmd.range_err = r_range;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_range <= 1'b0;
        end else begin
            r_state <= n_state;
            r_range <= n_range;
        end
    end

    `ACC_ASSERT_NEXT(a_op_to_exec, r_state == S_OP, r_state == S_EXEC)
    `ACC_ASSERT_NEXT(a_accept_busy, i_valid && o_ready, r_state != S_IDLE)
    `ACC_ASSERT_IMP(a_exec_slot_free, o_cmd.exec, i_stat.out_free)

endmodule
`default_nettype wire

### src/acc_cpu_dp.sv
`default_nettype none
`include "accumulator_cpu_core_defines.svh"
module acc_cpu_dp
    import acc_cpu_pkg::*;
#(
    parameter int MEM_DEPTH   = 65536,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic [DATA_W-1:0] i_in_char,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_read_data,
    output logic      [ST_W-1:0]   o_status,
    output logic                   o_char_valid,
    output logic      [DATA_W-1:0] o_char_out,
    output logic      [DATA_W-1:0] o_a_value,
    output logic      [DATA_W-1:0] o_b_value,
    output logic      [ADDR_W-1:0] o_pc_value,
    output logic      [SP_W-1:0]   o_sp_value
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_DEPTH);
    localparam logic [SP_W-1:0] STK_LIMIT = SP_W'(STACK_DEPTH);

    logic [MODE_W-1:0] r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic [DATA_W-1:0] r_char;
    logic [DATA_W-1:0] r_op;

    logic [ADDR_W-1:0] r_pc, n_pc;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [SP_W-1:0]   r_sp, n_sp;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    logic [ST_W-1:0]   r_status, n_status;
    logic              r_char_valid, n_char_valid;
    logic [DATA_W-1:0] r_char_out, n_char_out;

    logic [ADDR_W-1:0] pc1, pc2;
    logic [SP_W-1:0]   sp_m1;
    logic              req_addr_ok;
    logic              stk_room;
    logic [AW-1:0]     mem_raddr, mem_waddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata, stk_rdata;
    logic              mem_we, stk_we;
    logic              exec_ok;

    assign pc1         = r_pc + ADDR_W'(1);
    assign pc2         = r_pc + ADDR_W'(2);
    assign sp_m1       = r_sp - SP_W'(1);
    assign req_addr_ok = {1'b0, r_addr} < MEM_LIMIT;
    assign stk_room    = r_sp < STK_LIMIT;
    assign exec_ok     = (r_mode == MODE_EXEC) && !i_cmd.range_err;

    assign o_stat.addr_ok  = {1'b0, i_address} < MEM_LIMIT;
    assign o_stat.pc_ok    = {1'b0, r_pc} < MEM_LIMIT;
    assign o_stat.pc1_ok   = {1'b0, pc1} < MEM_LIMIT;
    assign o_stat.has_opnd = f_has_opnd(mem_rdata);
    assign o_stat.pop_ok   = (mem_rdata == OP_POP_B) && (r_sp != '0);
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_comb begin
        case (i_cmd.mem_sel)
            MSEL_PC:  mem_raddr = r_pc[AW-1:0];
            MSEL_PC1: mem_raddr = pc1[AW-1:0];
            default:  mem_raddr = i_address[AW-1:0];
        endcase
    end

    assign mem_we = i_cmd.exec &&
                    (((r_mode == MODE_WRITE) && req_addr_ok) ||
                     (exec_ok && (r_op == OP_STORE_A)));
    assign mem_waddr = (r_mode == MODE_WRITE) ? r_addr[AW-1:0] : AW'(mem_rdata);
    assign mem_wdata = (r_mode == MODE_WRITE) ? r_wdata : r_a;
    assign stk_we    = i_cmd.exec && exec_ok && (r_op == OP_PUSH_B) && stk_room;

    acc_cpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    acc_cpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp[SW-1:0]),
        .i_wdata (r_b),
        .i_re    (i_cmd.stk_re),
        .i_raddr (sp_m1[SW-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_pc         = r_pc;
        n_a          = r_a;
        n_b          = r_b;
        n_sp         = r_sp;
        n_read_data  = '0;
        n_status     = ST_OK;
        n_char_valid = 1'b0;
        n_char_out   = '0;
        case (r_mode)
            MODE_WRITE: begin
                if (!req_addr_ok) begin
                    n_status = ST_RANGE;
                end
            end
            MODE_READ: begin
                if (req_addr_ok) begin
                    n_read_data = mem_rdata;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            MODE_EXEC: begin
                if (i_cmd.range_err) begin
                    n_status = ST_RANGE;
                end else begin
                    n_pc = f_has_opnd(r_op) ? pc2 : pc1;
                    case (r_op)
                        OP_LOAD_A:  n_a = mem_rdata;
                        OP_LOAD_B:  n_b = mem_rdata;
                        OP_STORE_A: begin
                        end
                        OP_ADD:     n_a = r_a + r_b;
                        OP_SUB:     n_a = r_a - r_b;
                        OP_PUSH_B: begin
                            if (stk_room) begin
                                n_sp = r_sp + SP_W'(1);
                            end
                        end
                        OP_POP_B: begin
                            if (r_sp != '0) begin
                                n_sp = sp_m1;
                                n_b  = stk_rdata;
                            end
                        end
                        OP_JMP:     n_pc = ADDR_W'(mem_rdata);
                        OP_SYSCALL: begin
                            if (r_a == SYS_PUTC) begin
                                n_char_valid = 1'b1;
                                n_char_out   = r_b;
                            end else if (r_a == SYS_GETC) begin
                                n_b = r_char;
                            end else begin
                                n_status = ST_BADSYS;
                            end
                        end
                        OP_HALT:    n_status = ST_HALT;
                        default:    n_status = ST_BADOP;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_char  <= i_in_char;
        end
        if (i_cmd.cap_op) begin
            r_op <= mem_rdata;
        end
        if (i_cmd.exec) begin
            r_read_data  <= n_read_data;
            r_status     <= n_status;
            r_char_valid <= n_char_valid;
            r_char_out   <= n_char_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_pc        <= n_pc;
                r_a         <= n_a;
                r_b         <= n_b;
                r_sp        <= n_sp;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_status     = r_status;
    assign o_char_valid = r_char_valid;
    assign o_char_out   = r_char_out;
    assign o_a_value    = r_a;
    assign o_b_value    = r_b;
    assign o_pc_value   = r_pc;
    assign o_sp_value   = r_sp;

    `ACC_ASSERT(a_sp_bound, r_sp <= STK_LIMIT)
    `ACC_ASSERT_NEXT(a_exec_shows, i_cmd.exec, r_out_valid)
    `ACC_ASSERT_IMP(a_char_ok, r_out_valid && r_char_valid, r_status == ST_OK)

endmodule
`default_nettype wire

### src/accumulator_cpu_core.sv
// 8-bit accumulator processor with byte memory and a push-down stack.
// Request channel: i_valid/o_ready carrying i_mode, i_address, i_write_data,
// i_in_char. Mode write stores a byte, mode read returns one, mode execute
// runs the instruction at the program counter; any other mode just reports.
// Response channel: o_valid/i_ready, one response per request, carrying the
// read byte, status, emitted character and A, B, PC, SP after the request.
// Sequence: a write or read request goes to the execute state on acceptance,
// then into the response register; an execute request fetches the opcode at
// acceptance, then the operand or stack entry, then executes, an order set by
// the single read port of program memory. Execute waits while the response is
// stalled; the next request is taken once the previous one is committed.
// Reset (synchronous, active low) clears A, B, PC, SP and the response valid;
// program memory and stack contents are not cleared.
// If the receiver stalls, the response holds and the core finishes at most
// one more request, then waits before committing its results.
`default_nettype none
module accumulator_cpu_core
    import acc_cpu_pkg::*;
#(
    parameter int MEM_DEPTH   = 65536,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic [DATA_W-1:0] i_in_char,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_read_data,
    output logic      [ST_W-1:0]   o_status,
    output logic                   o_char_valid,
    output logic      [DATA_W-1:0] o_char_out,
    output logic      [DATA_W-1:0] o_a_value,
    output logic      [DATA_W-1:0] o_b_value,
    output logic      [ADDR_W-1:0] o_pc_value,
    output logic      [SP_W-1:0]   o_sp_value
);

    t_cmd  cmd;
    t_stat stat;

    acc_cpu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    acc_cpu_dp #(
        .MEM_DEPTH   (MEM_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_in_char    (i_in_char),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data),
        .o_status     (o_status),
        .o_char_valid (o_char_valid),
        .o_char_out   (o_char_out),
        .o_a_value    (o_a_value),
        .o_b_value    (o_b_value),
        .o_pc_value   (o_pc_value),
        .o_sp_value   (o_sp_value)
    );

endmodule
`default_nettype wire
